@@ rtl/core/lcd_decimal_digit_writer_assert.svh @@
// ----------------------------------------------------------------------------
// lcd_decimal_digit_writer_assert.svh
// assertion macros for the digit writer
// ----------------------------------------------------------------------------
`ifndef LCD_DECIMAL_DIGIT_WRITER_ASSERT_SVH
`define LCD_DECIMAL_DIGIT_WRITER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// clocked check, switched off while reset is asserted
`define LCD_DW_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define LCD_DW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LCD_DW_ASSERT(lbl, clk, rst_n, prop, msg)
`define LCD_DW_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ rtl/core/lcd_dw_pkg.sv @@
// ----------------------------------------------------------------------------
// lcd_dw_pkg
// shared constants, font table and types of the lcd decimal digit writer
// ----------------------------------------------------------------------------
package lcd_dw_pkg;

	localparam int DIGITS  = 6;
	localparam int ENTRIES = 12;
	localparam int ENTRY_W = 4;

	localparam logic       CMD_CHAR   = 1'b0;
	localparam logic       CMD_NUMBER = 1'b1;
	localparam logic [7:0] FONT_BASE  = 8'h30;

	// floor(t / 10) = (t * RECIP) >> 35 for any t below 2**32
	localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
	localparam int          DIV10_SHIFT = 35;
	localparam int          QUOT_W      = 28;
	localparam int          PROD_W      = 63;

	localparam logic [15:0] FONT [10] = '{
		16'h1551, 16'h8110, 16'h11e1, 16'h11b1, 16'h05b0,
		16'h14b1, 16'h14f1, 16'h1110, 16'h15f1, 16'h15b1
	};

	typedef struct packed {
		logic [QUOT_W-1:0] quot;
		logic [3:0]        digit;
	} div_res_t;

	typedef struct packed {
		logic               rd_en;
		logic [ENTRY_W-1:0] rd_addr;
		logic               wr_en;
		logic [ENTRY_W-1:0] wr_addr;
		logic [7:0]         wr_data;
	} mem_req_t;

	// nibble of a digit's font word, row 0 is the most significant
	function automatic logic [3:0] font_nibble(input logic [3:0] d, input logic [1:0] r);
		logic [15:0] w;
		begin
			w = FONT[d];
			unique case (r)
				2'd0: return w[15:12];
				2'd1: return w[11:8];
				2'd2: return w[7:4];
				2'd3: return w[3:0];
				default: return 4'h0;
			endcase
		end
	endfunction

endpackage

@@ rtl/core/lcd_dw_item_if.sv @@
// ----------------------------------------------------------------------------
// lcd_dw_item_if
// command channel: write one character or write a decimal number
// ----------------------------------------------------------------------------
interface lcd_dw_item_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [7:0]  char_code;
	logic [2:0]  position;
	logic [30:0] value;

	modport source (output valid, command, char_code, position, value, input ready);
	modport sink (input valid, command, char_code, position, value, output ready);
endinterface

@@ rtl/core/lcd_dw_write_if.sv @@
// ----------------------------------------------------------------------------
// lcd_dw_write_if
// register write channel towards the lcd controller
// ----------------------------------------------------------------------------
interface lcd_dw_write_if;
	logic       valid;
	logic       ready;
	logic [4:0] reg_addr;
	logic [7:0] reg_data;
	logic       last;

	modport source (output valid, reg_addr, reg_data, last, input ready);
	modport sink (input valid, reg_addr, reg_data, last, output ready);
endinterface

@@ rtl/core/lcd_dw_div10.sv @@
// ----------------------------------------------------------------------------
// lcd_dw_div10
// divide by ten through a reciprocal multiply, with the product registered
// ----------------------------------------------------------------------------
module lcd_dw_div10 (
	input  logic                  clk,
	input  logic [30:0]           t,
	output lcd_dw_pkg::div_res_t  res
);
	logic [lcd_dw_pkg::PROD_W-1:0] prod_s1;
	logic [3:0]                    tlow_s1;
	logic [lcd_dw_pkg::QUOT_W-1:0] quot;
	logic [3:0]                    q10_low;

	always_ff @(posedge clk) begin
		prod_s1 <= lcd_dw_pkg::PROD_W'(t) * lcd_dw_pkg::PROD_W'(lcd_dw_pkg::DIV10_RECIP);
		tlow_s1 <= t[3:0];
	end

	assign quot = prod_s1[lcd_dw_pkg::PROD_W-1:lcd_dw_pkg::DIV10_SHIFT];

	// remainder is below ten, so four bits of t - 10q are enough
	assign q10_low = {quot[0], 3'b000} + {quot[2:0], 1'b0};

	assign res.quot  = quot;
	assign res.digit = tlow_s1 - q10_low;
endmodule

@@ rtl/core/lcd_dw_mem.sv @@
// ----------------------------------------------------------------------------
// lcd_dw_mem
// display byte store, one read and one write port, registered read data
// ----------------------------------------------------------------------------
module lcd_dw_mem (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lcd_dw_pkg::mem_req_t req,
	output logic [7:0]           rd_data
);
	logic [7:0]                     mem [lcd_dw_pkg::ENTRIES];
	logic [lcd_dw_pkg::ENTRIES-1:0] valid_q;
	logic [7:0]                     rd_q;
	logic                           rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q <= mem[req.rd_addr];
		end
	end

	// entries never written read as zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : 8'h00;
endmodule

@@ rtl/core/lcd_decimal_digit_writer.sv @@
// ----------------------------------------------------------------------------
// lcd_decimal_digit_writer
// six-digit segment lcd writer: keeps the twelve display bytes and reports
// every byte it changes as a register write
// ----------------------------------------------------------------------------
// One command is taken at a time; items.ready is high only while no command
// is in progress. Each display byte is a read-modify-write of the byte store
// (read in ST_RD, then merged with the font nibble and written back in ST_WR).
// A character '0' to '9' at position 0 to 5 writes four bytes; any other
// character writes nothing. A number goes through the divide by ten (ST_DIV0,
// ST_DIV1) and then four byte updates per digit, for up to six digits. The
// byte store comes out of reset cleared at once, with no sweep. A result beat
// waits in an output register, so a stalled consumer only holds the block
// when the next byte is ready to go out.
// ----------------------------------------------------------------------------
`include "lcd_decimal_digit_writer_assert.svh"

module lcd_decimal_digit_writer (
	input  logic           clk,
	input  logic           arst_n,
	lcd_dw_item_if.sink    items,
	lcd_dw_write_if.source writes
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV0 = 5'b00010,
		ST_DIV1 = 5'b00100,
		ST_RD   = 5'b01000,
		ST_WR   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	logic [30:0] t_q, t_d;
	logic [2:0]  pos_q, pos_d;
	logic [3:0]  digit_q, digit_d;
	logic [1:0]  row_q, row_d;
	logic        last_digit_q, last_digit_d;

	logic        wr_valid_q;
	logic [4:0]  wr_addr_q;
	logic [7:0]  wr_data_q;
	logic        wr_last_q;

	logic        accept;
	logic        out_free;
	logic        out_load;
	logic        char_ok;
	logic [1:0]  pair;
	logic [lcd_dw_pkg::ENTRY_W-1:0] entry;
	logic [4:0]  reg_addr;
	logic [3:0]  nib;
	logic [7:0]  rd_data;
	logic [7:0]  new_byte;

	lcd_dw_pkg::mem_req_t mem_req;
	lcd_dw_pkg::div_res_t div_res;

	lcd_dw_div10 u_div (
		.clk (clk),
		.t   (t_q),
		.res (div_res)
	);

	lcd_dw_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	assign items.ready = (state_q == ST_IDLE);
	assign accept      = items.valid && items.ready;
	assign out_free    = !wr_valid_q || writes.ready;
	assign out_load    = (state_q == ST_WR) && out_free;

	assign char_ok = (items.char_code >= lcd_dw_pkg::FONT_BASE)
		&& (items.char_code <= lcd_dw_pkg::FONT_BASE + 8'd9)
		&& (items.position < 3'(lcd_dw_pkg::DIGITS));

	// byte index is pair + 3*row, lcd register is pair + 5*row
	assign pair     = pos_q[2:1];
	assign entry    = {2'b00, pair} + {1'b0, row_q, 1'b0} + {2'b00, row_q};
	assign reg_addr = {3'b000, pair} + {1'b0, row_q, 2'b00} + {3'b000, row_q};

	assign nib      = lcd_dw_pkg::font_nibble(digit_q, row_q);
	assign new_byte = pos_q[0] ? {nib, rd_data[3:0]} : {rd_data[7:4], nib};

	always_comb begin
		mem_req.rd_en   = (state_q == ST_RD);
		mem_req.rd_addr = entry;
		mem_req.wr_en   = out_load;
		mem_req.wr_addr = entry;
		mem_req.wr_data = new_byte;
	end

	always_comb begin
		state_d      = state_q;
		t_d          = t_q;
		pos_d        = pos_q;
		digit_d      = digit_q;
		row_d        = row_q;
		last_digit_d = last_digit_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (items.command == lcd_dw_pkg::CMD_NUMBER) begin
						t_d     = items.value;
						pos_d   = 3'(lcd_dw_pkg::DIGITS - 1);
						state_d = ST_DIV0;
					end else if (char_ok) begin
						digit_d      = 4'(items.char_code - lcd_dw_pkg::FONT_BASE);
						pos_d        = items.position;
						row_d        = 2'd0;
						last_digit_d = 1'b1;
						state_d      = ST_RD;
					end
				end
			end
			ST_DIV0: begin
				state_d = ST_DIV1;
			end
			ST_DIV1: begin
				// a further digit is drawn only while the quotient is non-zero and the position is above zero
				digit_d      = div_res.digit;
				t_d          = 31'(div_res.quot);
				last_digit_d = (div_res.quot == '0) || (pos_q == 3'd0);
				row_d        = 2'd0;
				state_d      = ST_RD;
			end
			ST_RD: begin
				state_d = ST_WR;
			end
			ST_WR: begin
				if (out_free) begin
					if (row_q == 2'd3) begin
						if (last_digit_q) begin
							state_d = ST_IDLE;
						end else begin
							pos_d   = pos_q - 3'd1;
							state_d = ST_DIV0;
						end
					end else begin
						row_d   = row_q + 2'd1;
						state_d = ST_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wr_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				wr_valid_q <= 1'b1;
			end else if (writes.ready) begin
				wr_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		t_q          <= t_d;
		pos_q        <= pos_d;
		digit_q      <= digit_d;
		row_q        <= row_d;
		last_digit_q <= last_digit_d;
		if (out_load) begin
			wr_addr_q <= reg_addr;
			wr_data_q <= new_byte;
			wr_last_q <= last_digit_q && (row_q == 2'd3);
		end
	end

	assign writes.valid    = wr_valid_q;
	assign writes.reg_addr = wr_addr_q;
	assign writes.reg_data = wr_data_q;
	assign writes.last     = wr_last_q;

	`LCD_DW_ASSERT(a_pos_in_range, clk, arst_n, (state_q == ST_RD) |-> (pos_q < 3'(lcd_dw_pkg::DIGITS)), "digit position out of range on byte read")
	`LCD_DW_ASSERT(a_digit_decimal, clk, arst_n, (state_q == ST_DIV1) |-> (div_res.digit <= 4'd9), "divide by ten gave a remainder above nine")
	`LCD_DW_ASSERT(a_beat_from_write, clk, arst_n, $rose(writes.valid) |-> $past(state_q == ST_WR), "result beat raised outside the byte write step")
	`LCD_DW_ASSERT_ALWAYS(a_idle_in_reset, clk, !arst_n |=> (state_q == ST_IDLE) && !writes.valid, "sequencer not idle after reset")

endmodule

@@ tb/lcd_dw_display_checker.sv @@
// ----------------------------------------------------------------------------
// lcd_dw_display_checker
// watches the command and register write channels, keeps its own copy of the
// twelve display bytes, predicts every register write and compares each beat
// ----------------------------------------------------------------------------
module lcd_dw_display_checker
	import lcd_dw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	lcd_dw_item_if  items,
	lcd_dw_write_if writes,
	output int      failures,
	output int      outstanding
);

	typedef struct packed {
		logic [4:0] addr;
		logic [7:0] data;
		logic       last;
	} reg_write_t;

	localparam logic [15:0] GLYPH [10] = '{
		16'h1551, 16'h8110, 16'h11e1, 16'h11b1, 16'h05b0,
		16'h14b1, 16'h14f1, 16'h1110, 16'h15f1, 16'h15b1
	};

	logic [7:0] shadow_bytes [ENTRIES];
	reg_write_t digit_writes [$];
	reg_write_t expected_writes [$];
	int         mismatches;

	// four read-modify-writes, one per nibble row of the glyph
	function automatic void draw_digit(input int unsigned d, input int unsigned pos);
		int unsigned slot;
		int unsigned r;
		logic [3:0]  nib;
		reg_write_t  w;
		if (d > 9 || pos >= DIGITS)
			return;
		for (r = 0; r < 4; r++) begin
			slot = pos / 2 + 3 * r;
			nib  = GLYPH[d][15 - 4 * r -: 4];
			if (pos % 2 == 1)
				shadow_bytes[slot] = {nib, shadow_bytes[slot][3:0]};
			else
				shadow_bytes[slot] = {shadow_bytes[slot][7:4], nib};
			w.addr = 5'(pos / 2 + 5 * r);
			w.data = shadow_bytes[slot];
			w.last = 1'b0;
			digit_writes.push_back(w);
		end
	endfunction

	function automatic void predict_writes(input logic cmd, input logic [7:0] ch,
			input logic [2:0] pos, input logic [30:0] val);
		int unsigned t;
		int unsigned n;
		int          p;
		digit_writes.delete();
		if (cmd == CMD_CHAR) begin
			if (ch >= FONT_BASE && ch <= FONT_BASE + 9)
				draw_digit(ch - FONT_BASE, pos);
		end else begin
			t = val;
			n = 1;
			while (t >= 10) begin
				t = t / 10;
				n++;
			end
			if (n > DIGITS)
				n = DIGITS;
			// right-aligned, least significant digit first
			t = val;
			p = DIGITS - 1;
			repeat (n) begin
				draw_digit(t % 10, p);
				t = t / 10;
				p--;
			end
		end
		if (digit_writes.size() > 0)
			digit_writes[digit_writes.size() - 1].last = 1'b1;
		foreach (digit_writes[i])
			expected_writes.push_back(digit_writes[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reg_write_t got;
		reg_write_t want;
		if (!arst_n) begin
			foreach (shadow_bytes[i])
				shadow_bytes[i] = 8'h00;
			expected_writes.delete();
			mismatches = 0;
			failures    <= 0;
			outstanding <= 0;
		end else begin
			// a beat out at this edge always belongs to an earlier command
			if (writes.valid && writes.ready) begin
				got.addr = writes.reg_addr;
				got.data = writes.reg_data;
				got.last = writes.last;
				if (expected_writes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected write beat: addr %0d data %02h last %0b",
							got.addr, got.data, got.last);
				end else begin
					want = expected_writes.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("write beat mismatch: expected addr %0d data %02h last %0b, got addr %0d data %02h last %0b",
								want.addr, want.data, want.last, got.addr, got.data, got.last);
					end
				end
			end
			if (items.valid && items.ready)
				predict_writes(items.command, items.char_code, items.position, items.value);
			failures    <= mismatches;
			outstanding <= expected_writes.size();
		end
	end

endmodule

@@ tb/tb_lcd_decimal_digit_writer.sv @@
// ----------------------------------------------------------------------------
// tb_lcd_decimal_digit_writer
// drives character and number commands into the digit writer with random gaps
// and back-pressure, and reports the verdict of the display checker
// ----------------------------------------------------------------------------
module tb_lcd_decimal_digit_writer;
	import lcd_dw_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 80;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   hold_requests = 0;
	int   holds_done    = 0;
	int   hold_left     = 0;
	int   cycles        = 0;
	int   failures;
	int   outstanding;

	lcd_dw_item_if  items ();
	lcd_dw_write_if writes ();

	lcd_decimal_digit_writer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.writes (writes)
	);

	lcd_dw_display_checker display_model (
		.clk         (clk),
		.arst_n      (arst_n),
		.items       (items),
		.writes      (writes),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// write channel consumer, with an occasional long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			writes.ready <= 1'b0;
		end else if (hold_requests != holds_done) begin
			holds_done   <= holds_done + 1;
			hold_left    <= HOLD_CYCLES;
			writes.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			writes.ready <= 1'b0;
		end else begin
			writes.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// called at a clock edge; returns at the edge where the beat is taken
	task automatic send_item(input logic cmd, input logic [7:0] ch, input logic [2:0] pos,
			input logic [30:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			items.valid <= 1'b0;
			@(posedge clk);
		end
		items.valid     <= 1'b1;
		items.command   <= cmd;
		items.char_code <= ch;
		items.position  <= pos;
		items.value     <= val;
		do
			@(posedge clk);
		while (!items.ready);
	endtask

	task automatic wait_drained();
		items.valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	// mostly well-formed commands, a few that draw nothing
	task automatic random_phase(input int count);
		int          done;
		int unsigned sel;
		int unsigned ndig;
		int unsigned bound;
		logic        cmd;
		logic [7:0]  ch;
		logic [2:0]  pos;
		logic [30:0] val;
		done = 0;
		while (done < count) begin
			sel = $urandom_range(99);
			val = 31'($urandom);
			ch  = 8'($urandom);
			pos = 3'($urandom);
			cmd = CMD_CHAR;
			if (sel < 50) begin
				cmd  = CMD_NUMBER;
				ndig = $urandom_range(1, 10);
				if (ndig < 10) begin
					bound = 10 ** ndig;
					val   = 31'($urandom % bound);
				end
			end else if (sel < 85) begin
				ch  = FONT_BASE + 8'($urandom_range(9));
				pos = 3'($urandom_range(DIGITS - 1));
			end
			done++;
			send_item(cmd, ch, pos, val);
		end
	endtask

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		items.valid     = 1'b0;
		items.command   = CMD_CHAR;
		items.char_code = 8'h00;
		items.position  = 3'd0;
		items.value     = 31'd0;
		send_idle_pct   = 27;
		recv_idle_pct   = 62;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// every glyph, every position
		for (int d = 0; d < 10; d++)
			send_item(CMD_CHAR, FONT_BASE + 8'(d), 3'(d % DIGITS), 31'($urandom));
		// characters that draw nothing
		send_item(CMD_CHAR, 8'h2f, 3'd0, 31'h7fffffff);
		send_item(CMD_CHAR, 8'h3a, 3'd1, 31'd0);
		send_item(CMD_CHAR, 8'hff, 3'd7, 31'd5);
		send_item(CMD_CHAR, 8'h00, 3'd2, 31'd0);
		send_item(CMD_CHAR, FONT_BASE + 8'd5, 3'd6, 31'd0);
		send_item(CMD_CHAR, FONT_BASE + 8'd8, 3'd7, 31'd0);
		// zero, short, full width and oversized numbers
		send_item(CMD_NUMBER, 8'hff, 3'd7, 31'd0);
		send_item(CMD_NUMBER, 8'h00, 3'd0, 31'd7);
		send_item(CMD_NUMBER, 8'h35, 3'd3, 31'd42);
		send_item(CMD_NUMBER, 8'h00, 3'd0, 31'd123);
		send_item(CMD_NUMBER, 8'h00, 3'd0, 31'd999999);
		send_item(CMD_NUMBER, 8'h00, 3'd0, 31'd1000000);
		send_item(CMD_NUMBER, 8'h00, 3'd0, 31'h7fffffff);
		send_item(CMD_NUMBER, 8'h00, 3'd0, 31'd305419896);
		wait_drained();

		random_phase(60);
		// consumer stalls for a long stretch while commands keep coming
		hold_requests <= hold_requests + 1;
		random_phase(50);
		wait_drained();

		send_idle_pct = 62;
		recv_idle_pct <= 27;
		random_phase(110);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct <= 0;
		random_phase(110);
		wait_drained();

		repeat (SETTLE) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/lcd_dw_pkg.sv
rtl/core/lcd_dw_item_if.sv
rtl/core/lcd_dw_write_if.sv
rtl/core/lcd_dw_div10.sv
rtl/core/lcd_dw_mem.sv
rtl/core/lcd_decimal_digit_writer.sv
tb/lcd_dw_display_checker.sv
tb/tb_lcd_decimal_digit_writer.sv
